/* rtl/svpl_pkg.sv */
// ---------------------------------------------------------------------------
// svpl_pkg
// Shared constants and types for the stereo volume and peak limiter block.
// ---------------------------------------------------------------------------
package svpl_pkg;

  localparam int SAMPLE_BITS = 24;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // APB register map, one 32-bit word per register
  localparam int APB_AW = 5;
  localparam int REG_IW = 3;

  localparam logic [REG_IW-1:0] REG_VOLUME_GAIN   = 3'd0;
  localparam logic [REG_IW-1:0] REG_MUTE          = 3'd1;
  localparam logic [REG_IW-1:0] REG_LIMITER_EN    = 3'd2;
  localparam logic [REG_IW-1:0] REG_CEILING_DB    = 3'd3;
  localparam logic [REG_IW-1:0] REG_ALPHA_ATTACK  = 3'd4;
  localparam logic [REG_IW-1:0] REG_ALPHA_RELEASE = 3'd5;
  localparam logic [REG_IW-1:0] REG_VOL_ALPHA     = 3'd6;

  // dB quantities in Q16 (1/65536 dB); CEIL_MIN is in Q8 (1/256 dB)
  localparam int ENV_MIN_Q16   = -3932160;
  localparam int DET_FLOOR_Q16 = -6553600;
  localparam int CEIL_MIN      = -6144;

  // log2 -> dB and dB -> log2 scale factors
  localparam int LOG2_TO_DB = 394566;
  localparam int DB_TO_LOG2 = 2786635;

  // Cubic 2^f approximation, Q16
  localparam int EXP_C3 = 5129;
  localparam int EXP_C2 = 14823;
  localparam int EXP_C1 = 45584;
  localparam int EXP_C0 = 65536;

endpackage

/* rtl/svpl_frame_if.sv */
// ---------------------------------------------------------------------------
// svpl_frame_if
// Input channel: one stereo frame per item.
// ---------------------------------------------------------------------------
interface svpl_frame_if import svpl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic                          end_of_block;

  modport source (output valid, sample_left, sample_right, end_of_block, input ready);
  modport sink   (input valid, sample_left, sample_right, end_of_block, output ready);
endinterface

/* rtl/svpl_result_if.sv */
// ---------------------------------------------------------------------------
// svpl_result_if
// Output channel: processed stereo frame and gain reduction report.
// ---------------------------------------------------------------------------
interface svpl_result_if import svpl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic signed [14:0]            gain_reduction;
  logic                          block_done;

  modport source (output valid, out_left, out_right, gain_reduction, block_done,
                  input ready);
  modport sink   (input valid, out_left, out_right, gain_reduction, block_done,
                  output ready);
endinterface

/* rtl/stereo_volume_peak_limiter.sv */
// ---------------------------------------------------------------------------
// stereo_volume_peak_limiter
// Master volume with mute and a feedforward peak limiter tracked in dB.
// ---------------------------------------------------------------------------
// One frame is processed at a time by a sequencer around a single registered
// 33x33 multiplier; the frame channel is ready only while the sequencer is
// idle, and a finished result waits in the output register while the next
// frame is taken. With the limiter on, a taken frame passes through gain
// smoothing, scaling and peak, normalisation of the peak (one bit a cycle),
// the 16 squaring steps of the log2, the dB and envelope update, the two
// dB-to-gain conversions (envelope and ceiling) and output scaling and
// hand-off. A silent frame skips the log2. With the limiter off only the
// ceiling conversion runs. The hand-off cycle stretches while the previous
// result is still waiting, and the frame channel is ready again in the idle
// cycle that follows. The log2 squaring loop through the shared multiplier
// dominates. Configuration is written over APB at byte address 4*index and
// may be read back; write it only while no frame is in flight.
// ---------------------------------------------------------------------------
module stereo_volume_peak_limiter import svpl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  svpl_frame_if.sink        frame_i,
  svpl_result_if.source     result_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SMUL, S_SUPD, S_LMUL, S_RMUL, S_RSAT, S_PEAK, S_NORM,
    S_SQMUL, S_SQUPD, S_DBMUL, S_DBRND, S_TGT, S_EMUL, S_EUPD, S_BMIN,
    S_GMUL, S_GSPLIT, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
    S_OLMUL, S_ORMUL, S_OLAST, S_DONE
  } state_e;

  localparam int SB = SAMPLE_BITS;

  // Round half up then arithmetic shift right
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] x,
                                                  input int unsigned n);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (n - 1);
    return (x + half) >>> n;
  endfunction

  // Saturate to the sample range
  function automatic logic signed [SB-1:0] sat(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = (PROD_W'(1) <<< (SB - 1)) - PROD_W'(1);
    lo = -(PROD_W'(1) <<< (SB - 1));
    if (x > hi) return SB'(hi);
    if (x < lo) return SB'(lo);
    return x[SB-1:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic [23:0]        vol_q;
  logic               mute_q;
  logic               lim_en_q;
  logic signed [13:0] ceil_db_q;
  logic [15:0]        att_q;
  logic [15:0]        rel_q;
  logic [15:0]        vsa_q;

  logic              cfg_wr;
  logic [REG_IW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q     <= 24'd4194304;
      mute_q    <= 1'b0;
      lim_en_q  <= 1'b1;
      ceil_db_q <= '0;
      att_q     <= 16'd6554;
      rel_q     <= 16'd66;
      vsa_q     <= 16'd68;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VOLUME_GAIN:   vol_q     <= pwdata[23:0];
        REG_MUTE:          mute_q    <= pwdata[0];
        REG_LIMITER_EN:    lim_en_q  <= pwdata[0];
        REG_CEILING_DB:    ceil_db_q <= pwdata[13:0];
        REG_ALPHA_ATTACK:  att_q     <= pwdata[15:0];
        REG_ALPHA_RELEASE: rel_q     <= pwdata[15:0];
        REG_VOL_ALPHA:     vsa_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VOLUME_GAIN:   prdata = {8'd0, vol_q};
      REG_MUTE:          prdata = {31'd0, mute_q};
      REG_LIMITER_EN:    prdata = {31'd0, lim_en_q};
      REG_CEILING_DB:    prdata = {{18{ceil_db_q[13]}}, ceil_db_q};
      REG_ALPHA_ATTACK:  prdata = {16'd0, att_q};
      REG_ALPHA_RELEASE: prdata = {16'd0, rel_q};
      REG_VOL_ALPHA:     prdata = {16'd0, vsa_q};
      default:           prdata = '0;
    endcase
  end

  // Ceiling clamped to -24..0 dB, then to Q16 dB
  logic signed [13:0] cdb;
  logic signed [21:0] cdb16;

  always_comb begin
    if (ceil_db_q > 14'sd0) begin
      cdb = '0;
    end else if (ceil_db_q < 14'(CEIL_MIN)) begin
      cdb = 14'(CEIL_MIN);
    end else begin
      cdb = ceil_db_q;
    end
    cdb16 = {cdb, 8'd0};
  end

  // ---------------- datapath state ----------------
  state_e             state_q;
  logic [23:0]        g_q;
  logic signed [22:0] env_q;
  logic signed [22:0] bmin_q;
  logic signed [SB-1:0] sl_q, sr_q;
  logic               eob_q;
  logic [31:0]        m_q;
  logic [4:0]         e_q;
  logic [3:0]         k_q;
  logic [15:0]        frac_q;
  logic signed [23:0] pdb_q;
  logic signed [23:0] tdb_q;
  logic               gsel_q;
  logic signed [7:0]  i_q;
  logic [15:0]        f_q;
  logic [16:0]        hp_q;
  logic [24:0]        lim_q;
  logic [24:0]        ceil_q;
  logic signed [SB-1:0] ol_q, or_q;

  logic                 out_vld_q;
  logic signed [SB-1:0] out_l_q, out_r_q;
  logic signed [14:0]   gr_q;
  logic                 done_q;

  // ---------------- shared multiplier ----------------
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] p_q;

  svpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  logic signed [PROD_W-1:0] r16, r22, r23, r24;
  logic signed [24:0]       gdiff;
  logic signed [21:0]       l2;
  logic [5:0]               ex6;
  logic [SB-1:0]            peak;
  logic [SB:0]              mag_l, mag_r;
  logic signed [PROD_W-1:0] g_d, env_d, pdb_d;
  logic signed [24:0]       tdb_d;
  logic [32:0]              sq_t;
  logic [17:0]              mant;
  logic [24:0]              mantx, gain_d;
  logic [7:0]               sh;

  // Output value: round, clamp to the linear ceiling, saturate
  function automatic logic signed [SB-1:0] oclamp(input logic signed [PROD_W-1:0] v,
                                                 input logic [24:0] c);
    logic signed [PROD_W-1:0] cs;
    cs = PROD_W'(c);
    if (v > cs) return sat(cs);
    if (v < -cs) return sat(-cs);
    return sat(v);
  endfunction

  always_comb begin
    r16   = rnd(p_q, 16);
    r22   = rnd(p_q, 22);
    r23   = rnd(p_q, 23);
    r24   = rnd(p_q, 24);
    gdiff = $signed({1'b0, (mute_q ? 24'd0 : vol_q)}) - $signed({1'b0, g_q});
    ex6   = 6'({1'b0, e_q}) - 6'd23;
    l2    = $signed({ex6, frac_q});
    mag_l = sl_q[SB-1] ? (SB+1)'(-$signed({sl_q[SB-1], sl_q})) : {1'b0, sl_q};
    mag_r = sr_q[SB-1] ? (SB+1)'(-$signed({sr_q[SB-1], sr_q})) : {1'b0, sr_q};
    peak  = (mag_l > mag_r) ? mag_l[SB-1:0] : mag_r[SB-1:0];

    // Gain smoother update, clamped to the register range
    g_d = PROD_W'($signed({1'b0, g_q})) + r16;
    if (g_d < 0) g_d = '0;
    else if (g_d > PROD_W'(24'hFFFFFF)) g_d = PROD_W'(24'hFFFFFF);

    // Envelope update, clamped to -60..0 dB
    env_d = PROD_W'(env_q) + r16;
    if (env_d > 0) env_d = '0;
    else if (env_d < PROD_W'(ENV_MIN_Q16)) env_d = PROD_W'(ENV_MIN_Q16);

    pdb_d = r16;
    if (pdb_d < PROD_W'(DET_FLOOR_Q16)) pdb_d = PROD_W'(DET_FLOOR_Q16);

    tdb_d = 25'(cdb16) - 25'(pdb_q);
    if (tdb_d > 0) tdb_d = '0;

    sq_t   = p_q[63:31];
    mant   = 18'(EXP_C0) + 18'(p_q[33:16]);
    mantx  = {mant, 7'd0};
    sh     = 8'(-i_q);
    gain_d = i_q[7] ? (mantx >> sh) : mantx;

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SMUL:  begin mul_a = MUL_W'(gdiff);            mul_b = MUL_W'(vsa_q);      end
      S_LMUL:  begin mul_a = MUL_W'(sl_q);             mul_b = MUL_W'(g_q);        end
      S_RMUL:  begin mul_a = MUL_W'(sr_q);             mul_b = MUL_W'(g_q);        end
      S_SQMUL: begin mul_a = MUL_W'(m_q);              mul_b = MUL_W'(m_q);        end
      S_DBMUL: begin mul_a = MUL_W'(l2);               mul_b = MUL_W'(LOG2_TO_DB); end
      S_EMUL:  begin
        mul_a = MUL_W'(tdb_q) - MUL_W'(env_q);
        mul_b = (tdb_q < 24'(env_q)) ? MUL_W'(att_q) : MUL_W'(rel_q);
      end
      S_GMUL:  begin
        mul_a = gsel_q ? MUL_W'(cdb16) : MUL_W'(env_q);
        mul_b = MUL_W'(DB_TO_LOG2);
      end
      S_H1:    begin mul_a = MUL_W'(EXP_C3);           mul_b = MUL_W'(f_q);        end
      S_H3,
      S_H5:    begin mul_a = MUL_W'(hp_q);             mul_b = MUL_W'(f_q);        end
      S_OLMUL: begin mul_a = MUL_W'(sl_q);             mul_b = MUL_W'(lim_q);      end
      S_ORMUL: begin mul_a = MUL_W'(sr_q);             mul_b = MUL_W'(lim_q);      end
      default: ;
    endcase
  end

  assign frame_i.ready           = (state_q == S_IDLE);
  assign result_o.valid          = out_vld_q;
  assign result_o.out_left       = out_l_q;
  assign result_o.out_right      = out_r_q;
  assign result_o.gain_reduction = gr_q;
  assign result_o.block_done     = done_q;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      g_q       <= 24'd4194304;
      env_q     <= '0;
      bmin_q    <= '0;
      out_vld_q <= 1'b0;
      gsel_q    <= 1'b0;
    end else begin
      // Drop the result once taken; the hand-off state reloads it itself
      if (out_vld_q && result_o.ready && (state_q != S_DONE)) out_vld_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (frame_i.valid) begin
            sl_q    <= frame_i.sample_left;
            sr_q    <= frame_i.sample_right;
            eob_q   <= frame_i.end_of_block;
            state_q <= S_SMUL;
          end
        end
        S_SMUL: state_q <= S_SUPD;
        S_SUPD: begin
          g_q     <= g_d[23:0];
          state_q <= S_LMUL;
        end
        S_LMUL: state_q <= S_RMUL;
        S_RMUL: begin
          sl_q    <= sat(r22);
          state_q <= S_RSAT;
        end
        S_RSAT: begin
          sr_q    <= sat(r22);
          state_q <= S_PEAK;
        end
        S_PEAK: begin
          if (!lim_en_q) begin
            // Bypass: unity limiter gain, envelope and block minimum hold
            lim_q   <= 25'd1 << 23;
            gsel_q  <= 1'b1;
            state_q <= S_GMUL;
          end else if (peak == '0) begin
            pdb_q   <= 24'(DET_FLOOR_Q16);
            state_q <= S_TGT;
          end else begin
            m_q     <= {peak, 8'd0};
            e_q     <= 5'd23;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          // Normalise one bit a cycle
          if (m_q[31]) begin
            k_q     <= '0;
            frac_q  <= '0;
            state_q <= S_SQMUL;
          end else begin
            m_q <= {m_q[30:0], 1'b0};
            e_q <= e_q - 5'd1;
          end
        end
        S_SQMUL: state_q <= S_SQUPD;
        S_SQUPD: begin
          frac_q  <= {frac_q[14:0], sq_t[32]};
          m_q     <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
          k_q     <= k_q + 4'd1;
          state_q <= (k_q == 4'd15) ? S_DBMUL : S_SQMUL;
        end
        S_DBMUL: state_q <= S_DBRND;
        S_DBRND: begin
          pdb_q   <= pdb_d[23:0];
          state_q <= S_TGT;
        end
        S_TGT: begin
          tdb_q   <= tdb_d[23:0];
          state_q <= S_EMUL;
        end
        S_EMUL: state_q <= S_EUPD;
        S_EUPD: begin
          env_q   <= env_d[22:0];
          state_q <= S_BMIN;
        end
        S_BMIN: begin
          if (env_q < bmin_q) bmin_q <= env_q;
          gsel_q  <= 1'b0;
          state_q <= S_GMUL;
        end
        S_GMUL: state_q <= S_GSPLIT;
        S_GSPLIT: begin
          i_q     <= r24[23:16];
          f_q     <= r24[15:0];
          state_q <= S_H1;
        end
        S_H1: state_q <= S_H2;
        S_H2: begin
          hp_q    <= 17'(EXP_C2) + p_q[32:16];
          state_q <= S_H3;
        end
        S_H3: state_q <= S_H4;
        S_H4: begin
          hp_q    <= 17'(EXP_C1) + p_q[32:16];
          state_q <= S_H5;
        end
        S_H5: state_q <= S_H6;
        S_H6: begin
          if (!gsel_q) begin
            lim_q   <= gain_d;
            gsel_q  <= 1'b1;
            state_q <= S_GMUL;
          end else begin
            // Q1.23 ceiling gain equals the sample-scale ceiling at 24-bit samples
            ceil_q  <= gain_d;
            state_q <= S_OLMUL;
          end
        end
        S_OLMUL: state_q <= S_ORMUL;
        S_ORMUL: begin
          ol_q    <= oclamp(r23, ceil_q);
          state_q <= S_OLAST;
        end
        S_OLAST: begin
          or_q    <= oclamp(r23, ceil_q);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_vld_q || result_o.ready) begin
            out_vld_q <= 1'b1;
            out_l_q   <= ol_q;
            out_r_q   <= or_q;
            gr_q      <= bmin_q[22:8];
            done_q    <= eob_q;
            if (eob_q) bmin_q <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (env_q <= 23'sd0) && (env_q >= 23'(ENV_MIN_Q16)))
    else $error("envelope out of range");

  a_bmin_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GMUL && !gsel_q) |-> (bmin_q <= env_q))
    else $error("block minimum above envelope");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_i.valid && frame_i.ready) |=> (state_q != S_IDLE))
    else $error("frame accepted but sequencer idle");

  a_gr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (gr_q <= 15'sd0))
    else $error("gain reduction positive");

endmodule

/* rtl/svpl_mul.sv */
// ---------------------------------------------------------------------------
// svpl_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module svpl_mul import svpl_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
